// ----- design/gccb_pkg.sv -----
// Shared widths, register indexes and reset values of the GC-content coverage binner.
package gccb_pkg;

  localparam int CHAR_W       = 8;
  localparam int WIN_W        = 16;
  localparam int BINS_W       = 7;
  localparam int BIN_IDX_W    = 6;
  localparam int COV_W        = 32;
  localparam int LAMBDA_W     = 32;
  localparam int HITS_W       = 48;
  localparam int LEN_W        = 40;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int DEF_MAX_BINS = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE   = 1'b1;

  localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RST = 16'd100;
  localparam logic [BINS_W-1:0] BINS_IN_USE_RST   = 7'd10;

endpackage

// ----- design/gccb_if.sv -----
// Valid/ready channel interfaces for bases in and bin results out.
interface gccb_in_if import gccb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] base_char;
  logic              masked;
  logic [COV_W-1:0]  coverage;
  logic              last_base;

  modport source (output valid, base_char, masked, coverage, last_base, input ready);
  modport sink   (input valid, base_char, masked, coverage, last_base, output ready);
endinterface

interface gccb_out_if import gccb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [LAMBDA_W-1:0]  lambda;
  logic [HITS_W-1:0]    hits_total;
  logic [LEN_W-1:0]     length_total;
  logic                 empty_bin;
  logic                 last_bin;

  modport source (output valid, bin_index, lambda, hits_total, length_total, empty_bin,
                  last_bin, input ready);
  modport sink   (input valid, bin_index, lambda, hits_total, length_total, empty_bin,
                  last_bin, output ready);
endinterface

// ----- design/gccb_divider.sv -----
// Shared restoring divider that produces one quotient bit per cycle.
module gccb_divider #(
  parameter int DW = 48,
  parameter int VW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VW-1:0] : trial[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/gccb_bin_store.sv -----
// Bin accumulator memory with registered read and per-entry valid flags.
module gccb_bin_store import gccb_pkg::*; #(
  parameter int  DEPTH = DEF_MAX_BINS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [HITS_W-1:0] rd_hits,
  output logic [LEN_W-1:0]  rd_len,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [HITS_W-1:0] wr_hits,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic              clr_all
);

  logic [HITS_W-1:0] hits_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem  [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [HITS_W-1:0] hits_q_r;
  logic [LEN_W-1:0]  len_q_r;
  logic              vld_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hits_mem[wr_addr] <= wr_hits;
      len_mem[wr_addr]  <= wr_len;
    end
    if (rd_en) begin
      hits_q_r <= hits_mem[rd_addr];
      len_q_r  <= len_mem[rd_addr];
      vld_q_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_hits = vld_q_r ? hits_q_r : '0;
  assign rd_len  = vld_q_r ? len_q_r : '0;

endmodule

// ----- design/gc_content_coverage_binner.sv -----
// Top level: window counting, bin update sequencer and readout of GC-content coverage bins.
// After a base that closes no binned window and ends no sequence, the next can follow at once.
// A base that closes a repeat-free window holding A/C/G/T bases holds off the next transfer
// while the shared 48-step divider finds the bin and the bin store is updated. On the last
// base the readout forms each non-empty bin's lambda with the same divider; empty bins skip it.
// Synchronous active-low reset clears the window, all bin valid flags and restores the registers.
module gc_content_coverage_binner import gccb_pkg::*; #(
  parameter int  MAX_BINS = DEF_MAX_BINS,
  localparam int AW       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gccb_in_if.sink               in_ch,
  gccb_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PROD_W = WIN_W + BINS_W;
  localparam logic [CHAR_W-1:0] CH_A_UP = "A";
  localparam logic [CHAR_W-1:0] CH_A_LO = "a";
  localparam logic [CHAR_W-1:0] CH_C_UP = "C";
  localparam logic [CHAR_W-1:0] CH_C_LO = "c";
  localparam logic [CHAR_W-1:0] CH_G_UP = "G";
  localparam logic [CHAR_W-1:0] CH_G_LO = "g";
  localparam logic [CHAR_W-1:0] CH_T_UP = "T";
  localparam logic [CHAR_W-1:0] CH_T_LO = "t";
  localparam logic [CHAR_W-1:0] CH_N_UP = "N";
  localparam logic [CHAR_W-1:0] CH_N_LO = "n";

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN_DIV,
    S_BIN_WR,
    S_RO_RD,
    S_RO_LOAD,
    S_RO_DIV,
    S_RO_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [WIN_W-1:0]     win_len_r;
  logic [BINS_W-1:0]    bins_r;
  logic [WIN_W-1:0]     pos_r, pos_nxt;
  logic [WIN_W-1:0]     gc_r, gc_nxt;
  logic [WIN_W-1:0]     at_r, at_nxt;
  logic                 rep_r, rep_nxt;
  logic [HITS_W-1:0]    cov_sum_r, cov_sum_nxt;
  logic                 last_r, last_nxt;
  logic [AW-1:0]        bin_r, bin_nxt;
  logic [BINS_W-1:0]    ro_cnt_r, ro_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BIN_IDX_W-1:0] out_bin_r, out_bin_nxt;
  logic [LAMBDA_W-1:0]  out_lambda_r, out_lambda_nxt;
  logic [HITS_W-1:0]    out_hits_r, out_hits_nxt;
  logic [LEN_W-1:0]     out_len_r, out_len_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [WIN_W-1:0]     eff_win;
  logic [BINS_W-1:0]    nb;
  logic                 is_gc, is_at, is_rep;
  logic [WIN_W-1:0]     gc_inc, at_inc, pos_inc;
  logic                 rep_inc;
  logic [HITS_W:0]      cov_add;
  logic [HITS_W-1:0]    cov_inc;
  logic                 close_w;
  logic [WIN_W:0]       base_cnt;
  logic [PROD_W-1:0]    bin_prod;
  logic [BINS_W-1:0]    bin_cl;
  logic [HITS_W:0]      hits_add;
  logic [LEN_W:0]       len_add;
  logic                 accept;

  logic                 div_start, div_done;
  logic [HITS_W-1:0]    div_dividend, div_quotient;
  logic [LEN_W-1:0]     div_divisor;

  logic                 rd_en, wr_en, clr_all;
  logic [AW-1:0]        rd_addr;
  logic [HITS_W-1:0]    rd_hits, wr_hits;
  logic [LEN_W-1:0]     rd_len, wr_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WINDOW_LENGTH_RST;
      bins_r    <= BINS_IN_USE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH: win_len_r <= cfg_wdata[WIN_W-1:0];
        CFG_BINS_IN_USE:   bins_r    <= cfg_wdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_win = (win_len_r == '0) ? WIN_W'(1) : win_len_r;
  assign nb = (bins_r == '0) ? BINS_W'(1) :
              (bins_r > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_r;

  assign is_gc = (in_ch.base_char == CH_C_UP) || (in_ch.base_char == CH_C_LO) ||
                 (in_ch.base_char == CH_G_UP) || (in_ch.base_char == CH_G_LO);
  assign is_at = (in_ch.base_char == CH_A_UP) || (in_ch.base_char == CH_A_LO) ||
                 (in_ch.base_char == CH_T_UP) || (in_ch.base_char == CH_T_LO);
  assign is_rep = in_ch.masked || (in_ch.base_char == CH_N_UP) ||
                  (in_ch.base_char == CH_N_LO);

  assign gc_inc   = gc_r + WIN_W'(is_gc);
  assign at_inc   = at_r + WIN_W'(is_at);
  assign pos_inc  = pos_r + WIN_W'(1);
  assign rep_inc  = rep_r || is_rep;
  assign cov_add  = {1'b0, cov_sum_r} + (HITS_W + 1)'(in_ch.coverage);
  assign cov_inc  = cov_add[HITS_W] ? '1 : cov_add[HITS_W-1:0];
  assign close_w  = in_ch.last_base || (pos_inc >= eff_win);
  assign base_cnt = {1'b0, gc_inc} + {1'b0, at_inc};
  assign bin_prod = PROD_W'(gc_inc) * PROD_W'(nb);
  assign bin_cl   = (div_quotient >= HITS_W'(nb)) ? (nb - BINS_W'(1)) :
                    div_quotient[BINS_W-1:0];
  assign hits_add = {1'b0, rd_hits} + {1'b0, cov_sum_r};
  assign len_add  = {1'b0, rd_len} + (LEN_W + 1)'(eff_win);
  assign accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    gc_nxt         = gc_r;
    at_nxt         = at_r;
    rep_nxt        = rep_r;
    cov_sum_nxt    = cov_sum_r;
    last_nxt       = last_r;
    bin_nxt        = bin_r;
    ro_cnt_nxt     = ro_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_bin_nxt    = out_bin_r;
    out_lambda_nxt = out_lambda_r;
    out_hits_nxt   = out_hits_r;
    out_len_nxt    = out_len_r;
    out_empty_nxt  = out_empty_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_hits        = hits_add[HITS_W] ? '1 : hits_add[HITS_W-1:0];
    wr_len         = len_add[LEN_W] ? '1 : len_add[LEN_W-1:0];
    clr_all        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt     = pos_inc;
          gc_nxt      = gc_inc;
          at_nxt      = at_inc;
          rep_nxt     = rep_inc;
          cov_sum_nxt = cov_inc;
          last_nxt    = in_ch.last_base;
          if (close_w) begin
            if ((base_cnt != '0) && !rep_inc) begin
              div_start    = 1'b1;
              div_dividend = HITS_W'(bin_prod);
              div_divisor  = LEN_W'(base_cnt + (WIN_W + 1)'(1));
              state_nxt    = S_BIN_DIV;
            end else begin
              pos_nxt     = '0;
              gc_nxt      = '0;
              at_nxt      = '0;
              rep_nxt     = 1'b0;
              cov_sum_nxt = '0;
              state_nxt   = in_ch.last_base ? S_RO_RD : S_IDLE;
            end
          end
        end
      end
      S_BIN_DIV: begin
        if (div_done) begin
          rd_en     = 1'b1;
          rd_addr   = bin_cl[AW-1:0];
          bin_nxt   = bin_cl[AW-1:0];
          state_nxt = S_BIN_WR;
        end
      end
      S_BIN_WR: begin
        wr_en       = 1'b1;
        pos_nxt     = '0;
        gc_nxt      = '0;
        at_nxt      = '0;
        rep_nxt     = 1'b0;
        cov_sum_nxt = '0;
        state_nxt   = last_r ? S_RO_RD : S_IDLE;
      end
      S_RO_RD: begin
        rd_en     = 1'b1;
        rd_addr   = ro_cnt_r[AW-1:0];
        state_nxt = S_RO_LOAD;
      end
      S_RO_LOAD: begin
        out_bin_nxt   = ro_cnt_r[BIN_IDX_W-1:0];
        out_hits_nxt  = rd_hits;
        out_len_nxt   = rd_len;
        out_empty_nxt = (rd_len == '0);
        out_last_nxt  = ((ro_cnt_r + BINS_W'(1)) == nb);
        if (rd_len == '0) begin
          out_lambda_nxt = '0;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_RO_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = rd_hits;
          div_divisor  = rd_len;
          state_nxt    = S_RO_DIV;
        end
      end
      S_RO_DIV: begin
        if (div_done) begin
          out_lambda_nxt = (div_quotient[HITS_W-1:LAMBDA_W] != '0) ? '1 :
                           div_quotient[LAMBDA_W-1:0];
          out_valid_nxt  = 1'b1;
          state_nxt      = S_RO_OUT;
        end
      end
      S_RO_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            clr_all    = 1'b1;
            ro_cnt_nxt = '0;
            state_nxt  = S_IDLE;
          end else begin
            ro_cnt_nxt = ro_cnt_r + BINS_W'(1);
            state_nxt  = S_RO_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_bin_r    <= out_bin_nxt;
    out_lambda_r <= out_lambda_nxt;
    out_hits_r   <= out_hits_nxt;
    out_len_r    <= out_len_nxt;
    out_empty_r  <= out_empty_nxt;
    out_last_r   <= out_last_nxt;
    bin_r        <= bin_nxt;
    last_r       <= last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      gc_r        <= '0;
      at_r        <= '0;
      rep_r       <= 1'b0;
      cov_sum_r   <= '0;
      ro_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      gc_r        <= gc_nxt;
      at_r        <= at_nxt;
      rep_r       <= rep_nxt;
      cov_sum_r   <= cov_sum_nxt;
      ro_cnt_r    <= ro_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  gccb_divider #(
    .DW (HITS_W),
    .VW (LEN_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  gccb_bin_store #(
    .DEPTH (MAX_BINS)
  ) u_bin_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_hits (rd_hits),
    .rd_len  (rd_len),
    .wr_en   (wr_en),
    .wr_addr (bin_r),
    .wr_hits (wr_hits),
    .wr_len  (wr_len),
    .clr_all (clr_all)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.bin_index    = out_bin_r;
  assign out_ch.lambda       = out_lambda_r;
  assign out_ch.hits_total   = out_hits_r;
  assign out_ch.length_total = out_len_r;
  assign out_ch.empty_bin    = out_empty_r;
  assign out_ch.last_bin     = out_last_r;

`ifndef SYNTHESIS
  a_out_only_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (state_r == S_RO_OUT))
    else $error("Result offered outside the readout hand-over state.");

  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("Input taken while a result is waiting.");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_BIN_DIV || state_r == S_RO_DIV))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_readout_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (ro_cnt_r < nb))
    else $error("Readout bin counter beyond the bins in use.");

  a_ready_after_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_bin) |=> in_ch.ready)
    else $error("Block not ready after the final bin transfer.");
`endif

endmodule

// ----- tb/gccb_test_pkg.sv -----
// Base letter codes shared by the binner test bench and its checker.
package gccb_test_pkg;

  localparam logic [7:0] L_A    = "A";
  localparam logic [7:0] L_C    = "C";
  localparam logic [7:0] L_G    = "G";
  localparam logic [7:0] L_T    = "T";
  localparam logic [7:0] L_N    = "N";
  localparam logic [7:0] L_A_LC = "a";
  localparam logic [7:0] L_C_LC = "c";
  localparam logic [7:0] L_G_LC = "g";
  localparam logic [7:0] L_T_LC = "t";
  localparam logic [7:0] L_N_LC = "n";

  localparam logic [3:0][7:0] GC_LETTERS = {L_G, L_C, L_G_LC, L_C_LC};
  localparam logic [3:0][7:0] AT_LETTERS = {L_A, L_T, L_A_LC, L_T_LC};

endpackage

// ----- tb/gccb_checker.sv -----
// Checker for the binner: predicts every bin report from observed transfers and compares.
module gccb_checker import gccb_pkg::*, gccb_test_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  gccb_in_if                    in_mon,
  gccb_out_if                   out_mon,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           pending,
  output int unsigned           fail_count
);

  localparam longint unsigned HITS_LIMIT   = (64'd1 << HITS_W) - 64'd1;
  localparam longint unsigned LEN_LIMIT    = (64'd1 << LEN_W) - 64'd1;
  localparam longint unsigned LAMBDA_LIMIT = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [LAMBDA_W-1:0]  lambda;
    logic [HITS_W-1:0]    hits_total;
    logic [LEN_W-1:0]     length_total;
    logic                 empty_bin;
    logic                 last_bin;
  } bin_report_t;

  bin_report_t       expected_reports[$];
  logic [WIN_W-1:0]  win_size;
  logic [BINS_W-1:0] bins_cfg;
  int unsigned       pos_in_window;
  int unsigned       gc_tally;
  int unsigned       at_tally;
  logic              saw_repeat;
  logic [HITS_W-1:0] cov_window_sum;
  logic [HITS_W-1:0] hits_acc [DEF_MAX_BINS];
  logic [LEN_W-1:0]  length_acc [DEF_MAX_BINS];

  function automatic longint unsigned sat_sum(input longint unsigned a, input longint unsigned b,
                                              input longint unsigned lim);
    longint unsigned s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic int unsigned win_effective();
    return (win_size == '0) ? 32'd1 : 32'(win_size);
  endfunction

  function automatic int unsigned bins_effective();
    if (bins_cfg == '0) return 32'd1;
    if (32'(bins_cfg) > DEF_MAX_BINS) return DEF_MAX_BINS;
    return 32'(bins_cfg);
  endfunction

  function automatic void restart_window();
    pos_in_window  = 0;
    gc_tally       = 0;
    at_tally       = 0;
    saw_repeat     = 1'b0;
    cov_window_sum = '0;
  endfunction

  function automatic void clear_bins();
    for (int k = 0; k < DEF_MAX_BINS; k++) begin
      hits_acc[k]   = '0;
      length_acc[k] = '0;
    end
  endfunction

  // A window with no A/C/G/T letters selects no bin at all.
  function automatic void finish_window();
    int unsigned nb;
    int unsigned sel;
    if (gc_tally + at_tally != 0) begin
      nb  = bins_effective();
      sel = (gc_tally * nb) / (gc_tally + at_tally + 1);
      if (sel >= nb) sel = nb - 1;
      if (!saw_repeat) begin
        hits_acc[sel]   = HITS_W'(sat_sum(64'(hits_acc[sel]), 64'(cov_window_sum), HITS_LIMIT));
        length_acc[sel] = LEN_W'(sat_sum(64'(length_acc[sel]), 64'(win_effective()), LEN_LIMIT));
      end
    end
    restart_window();
  endfunction

  function automatic void queue_readout();
    int unsigned     nb;
    bin_report_t     r;
    longint unsigned q;
    nb = bins_effective();
    for (int unsigned k = 0; k < nb; k++) begin
      r.bin_index    = BIN_IDX_W'(k);
      r.hits_total   = hits_acc[k];
      r.length_total = length_acc[k];
      r.empty_bin    = (length_acc[k] == '0);
      q = 0;
      if (!r.empty_bin) begin
        q = 64'(hits_acc[k]) / 64'(length_acc[k]);
        if (q > LAMBDA_LIMIT) q = LAMBDA_LIMIT;
      end
      r.lambda   = LAMBDA_W'(q);
      r.last_bin = (k + 1 == nb);
      expected_reports.push_back(r);
    end
    clear_bins();
  endfunction

  function automatic void fold_base(input logic [CHAR_W-1:0] ch, input logic msk,
                                    input logic [COV_W-1:0] cov, input logic ends_seq);
    if (ch == L_G || ch == L_C || ch == L_G_LC || ch == L_C_LC) gc_tally++;
    if (ch == L_A || ch == L_T || ch == L_A_LC || ch == L_T_LC) at_tally++;
    if (msk || ch == L_N || ch == L_N_LC) saw_repeat = 1'b1;
    cov_window_sum = HITS_W'(sat_sum(64'(cov_window_sum), 64'(cov), HITS_LIMIT));
    pos_in_window++;
    if (ends_seq || pos_in_window >= win_effective()) finish_window();
    if (ends_seq) queue_readout();
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bin_report_t want;
    if (!rst_n) begin
      win_size = WINDOW_LENGTH_RST;
      bins_cfg = BINS_IN_USE_RST;
      restart_window();
      clear_bins();
      expected_reports.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_WINDOW_LENGTH) win_size = cfg_wdata[WIN_W-1:0];
        else if (cfg_index == CFG_BINS_IN_USE) bins_cfg = cfg_wdata[BINS_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        fold_base(in_mon.base_char, in_mon.masked, in_mon.coverage, in_mon.last_base);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("bin report transfer with none expected, bin_index",
                          64'(out_mon.bin_index), 64'd0);
        end else begin
          want = expected_reports.pop_front();
          if (out_mon.bin_index !== want.bin_index)
            report_mismatch("bin_index", 64'(out_mon.bin_index), 64'(want.bin_index));
          if (out_mon.lambda !== want.lambda)
            report_mismatch("lambda", 64'(out_mon.lambda), 64'(want.lambda));
          if (out_mon.hits_total !== want.hits_total)
            report_mismatch("hits_total", 64'(out_mon.hits_total), 64'(want.hits_total));
          if (out_mon.length_total !== want.length_total)
            report_mismatch("length_total", 64'(out_mon.length_total), 64'(want.length_total));
          if (out_mon.empty_bin !== want.empty_bin)
            report_mismatch("empty_bin", 64'(out_mon.empty_bin), 64'(want.empty_bin));
          if (out_mon.last_bin !== want.last_bin)
            report_mismatch("last_bin", 64'(out_mon.last_bin), 64'(want.last_bin));
        end
      end
    end
    pending <= expected_reports.size();
  end

endmodule

// ----- tb/gc_content_coverage_binner_test.sv -----
// Test bench top: drives bases and register writes into the binner and gives the verdict.
module gc_content_coverage_binner_test import gccb_pkg::*, gccb_test_pkg::*; ;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           pending;
  int unsigned           fail_count;
  bit                    gaps_on;
  bit                    stall_on;
  int unsigned           sink_wait = 0;

  gccb_in_if  in_ch ();
  gccb_out_if out_ch ();

  gc_content_coverage_binner i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gccb_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_letter(input bit noisy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!noisy) r = r % 76;
    if (r < 38) return GC_LETTERS[$urandom_range(0, 3)];
    if (r < 76) return AT_LETTERS[$urandom_range(0, 3)];
    if (r < 84) return r[0] ? L_N : L_N_LC;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COV_W-1:0] pick_coverage();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 60) return COV_W'($urandom_range(0, 4095));
    return COV_W'($urandom());
  endfunction

  // The result side stalls in runs of random length while stalling is enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
    end else if (sink_wait != 0) begin
      out_ch.ready <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      sink_wait <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_base(input logic [CHAR_W-1:0] ch, input logic msk,
                           input logic [COV_W-1:0] cov, input logic ends_seq);
    int unsigned gap;
    in_ch.valid     <= 1'b1;
    in_ch.base_char <= ch;
    in_ch.masked    <= msk;
    in_ch.coverage  <= cov;
    in_ch.last_base <= ends_seq;
    do @(posedge clk); while (!in_ch.ready);
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(input int unsigned n, input bit closes, input bit noisy);
    for (int unsigned k = 0; k < n; k++) begin
      send_base(pick_letter(noisy), noisy && $urandom_range(0, 9) == 0, pick_coverage(),
                closes && k == n - 1);
    end
  endtask

  // Waits for every expected bin report, then for a window-end update still in flight.
  task automatic drain_and_wait();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] win_word,
                               input logic [CFG_DATA_W-1:0] bin_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_wdata <= win_word;
    @(posedge clk);
    cfg_index <= CFG_BINS_IN_USE;
    cfg_wdata <= bin_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned       random_items;
    int unsigned       n;
    int unsigned       r;
    logic [WIN_W-1:0]  win;
    logic [BINS_W-1:0] bin_set;
    bit                noisy;

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_index       = CFG_WINDOW_LENGTH;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.base_char = '0;
    in_ch.masked    = 1'b0;
    in_ch.coverage  = '0;
    in_ch.last_base = 1'b0;
    gaps_on         = 1'b1;
    stall_on        = 1'b1;
    random_items    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One short clean window with the settings from reset.
    send_base(L_G, 1'b0, '1, 1'b0);
    send_base(L_C_LC, 1'b0, '0, 1'b0);
    send_base(L_A_LC, 1'b0, 32'h100, 1'b0);
    send_base(L_T, 1'b0, 32'h1, 1'b1);
    drain_and_wait();

    // Zero window length and zero bin count both act as one.
    set_registers('0, '0);
    send_base(L_N, 1'b0, 32'h200, 1'b0);
    send_base(8'h00, 1'b0, 32'h300, 1'b0);
    send_base(L_G_LC, 1'b1, 32'h400, 1'b0);
    send_base(8'hFF, 1'b0, 32'h500, 1'b0);
    send_base(L_T, 1'b0, '1, 1'b1);
    drain_and_wait();

    // A bin count above the maximum saturates.
    set_registers(16'd3, 16'hFFFF);
    send_base(L_G, 1'b0, 32'h8000_0000, 1'b0);
    send_base(L_G, 1'b0, 32'h0000_0001, 1'b0);
    send_base(L_G, 1'b0, 32'h7FFF_FFFF, 1'b0);
    send_base(L_A, 1'b0, 32'h10, 1'b0);
    send_base(L_C, 1'b0, 32'h20, 1'b0);
    send_base(L_T_LC, 1'b0, 32'h30, 1'b0);
    send_base(L_C, 1'b0, '0, 1'b1);
    drain_and_wait();

    // Window length lowered mid-window: many bases over a length of one saturates lambda.
    set_registers(16'd200, 16'd2);
    repeat (4) send_base(L_A, 1'b0, '1, 1'b0);
    drain_and_wait();
    set_registers(16'd1, 16'd2);
    send_base(L_A, 1'b0, '1, 1'b1);
    drain_and_wait();

    // A bin filled under a wide count is left out of a narrower readout but still cleared.
    set_registers(16'd1, 16'd64);
    send_base(L_G, 1'b0, 32'h1234_5678, 1'b0);
    drain_and_wait();
    set_registers(16'd1, 16'd4);
    send_base(L_G, 1'b0, 32'h0000_0100, 1'b1);
    drain_and_wait();

    // Bases back to back with no stalls on either side.
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    set_registers(16'd6, 16'd1);
    for (int k = 0; k < 20; k++) send_base(pick_letter(1'b0), 1'b0, '1, k == 19);
    drain_and_wait();
    set_registers(16'd1, 16'd64);
    send_base(L_C, 1'b0, 32'h42, 1'b1);
    drain_and_wait();

    while (random_items < 140) begin
      r = $urandom_range(0, 9);
      if (r == 0) win = '0;
      else if (r == 1) win = '1;
      else if (r < 4) win = WIN_W'($urandom_range(9, 40));
      else win = WIN_W'($urandom_range(1, 8));
      r = $urandom_range(0, 9);
      if (r == 0) bin_set = '0;
      else if (r == 1) bin_set = 7'd64;
      else if (r == 2) bin_set = '1;
      else if (r == 3) bin_set = 7'd1;
      else bin_set = BINS_W'($urandom_range(2, 63));
      set_registers(win, {($urandom_range(0, 1) != 0) ? 9'($urandom()) : 9'd0, bin_set});
      gaps_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      noisy    = $urandom_range(0, 1) != 0;
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(3, 16);
        send_run(n, $urandom_range(0, 5) != 0, noisy);
        random_items += n;
      end
      drain_and_wait();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
